// ===== design/mpt_pkg.sv =====
package mpt_pkg;

    // Position format
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_WIDTH     = 47;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [63:0] POS_MAX64 = (64'(1) << POS_WIDTH) - 64'(1);

    // Field widths
    localparam int KIND_W     = 4;
    localparam int ELAP_W     = 32;
    localparam int SV_W       = 48;
    localparam int FCNT_W     = 16;
    localparam int DUR_W      = 47;
    localparam int SPEED_W    = 16;
    localparam int RATE_W     = 25;
    localparam int FPER_W     = 26;
    localparam int FRAME_W    = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 120;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd4;

    localparam logic [SPEED_W-1:0] SPEED_RST = 16'd256;
    localparam logic [RATE_W-1:0]  RATE_RST  = 25'd1572864;
    localparam logic [FPER_W-1:0]  FPER_RST  = 26'd2731;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_TICK      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PAUSE     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_STOP      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_TOGGLE    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SEEK      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SEEK_REL  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_STEP_FWD  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_STEP_BACK = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SYNC      = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SEEK_END  = 4'd10;

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Tick advance: Q16.16 * Q8.8 = Q.24, cut down to Q.F
    localparam int TICK_SHR  = 24 - POS_FRAC_BITS;
    localparam int DELTA_W   = ELAP_W + SPEED_W - TICK_SHR;
    localparam int SKIP_UNITS = ((1 << POS_FRAC_BITS) + 9999) / 10000;
    localparam int SUM_W = ((POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W) + 1;
    localparam int TGT_W = ((POS_WIDTH > SV_W) ? POS_WIDTH : SV_W) + 1;

    // Frame period in Q.F
    localparam int PER_SHL = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
    localparam int PER_SHR = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;

    // Frame numbers: full product of position and rate, scaled by 2^(F+16)
    localparam int PLO_W    = MUL_W + RATE_W;
    localparam int PF_W     = POS_WIDTH + RATE_W;
    localparam int FR_SHIFT = POS_FRAC_BITS + 16;
    localparam int FQ_W     = PF_W - FR_SHIFT + 1;

    // Duration as seen by the position logic
    function automatic logic [POS_WIDTH-1:0] eff_dur(input logic [DUR_W-1:0] dur);
        logic [POS_WIDTH-1:0] res;
        if (64'(dur) > POS_MAX64) begin
            res = POS_MAX;
        end else begin
            res = POS_WIDTH'(dur);
        end
        return res;
    endfunction

    // Floor or ceiling of the scaled product, saturated to 32 bits
    function automatic logic [FRAME_W-1:0] frames_of(input logic [PF_W-1:0] full,
                                                     input logic up);
        logic [FQ_W-1:0] q;
        logic            rem;
        logic [FRAME_W-1:0] res;
        q   = FQ_W'(full >> FR_SHIFT);
        rem = |full[FR_SHIFT-1:0];
        q   = q + FQ_W'(up && rem);
        if (|(q >> FRAME_W)) begin
            res = '1;
        end else begin
            res = FRAME_W'(q);
        end
        return res;
    endfunction

endpackage

// ===== design/mpt_mul.sv =====
module mpt_mul
    import mpt_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    // Registered product, one operand pair per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/mpt_mod.sv =====
module mpt_mod
    import mpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SUM_W-1:0]     i_dividend,
    input  logic [POS_WIDTH-1:0] i_divisor,
    output logic                 o_done,
    output logic [POS_WIDTH-1:0] o_rem
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                 r_act;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_dvd;
    logic [POS_WIDTH-1:0] r_rem;
    logic [POS_WIDTH:0]   w_trial;
    logic                 w_ge;
    logic [POS_WIDTH:0]   w_next;

    // One restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[SUM_W-1]};
        w_ge    = w_trial >= {1'b0, i_divisor};
        w_next  = w_ge ? (w_trial - {1'b0, i_divisor}) : w_trial;
    end

    // Bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_act <= 1'b1;
            r_cnt <= CNT_W'(SUM_W);
        end else if (r_act) begin
            if (r_cnt == '0) begin
                r_act <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Partial remainder and dividend shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_act && (r_cnt != '0)) begin
            r_dvd <= r_dvd << 1;
            r_rem <= POS_WIDTH'(w_next);
        end
    end

    assign o_done = r_act && (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

// ===== design/media_playback_position_timer_core.sv =====
// Path to a result: each item passes S_CMD, then S_FA to S_FF and the output load. Seek,
// sync and seek to end add S_CLAMP, relative seek S_OFS and S_CLAMP, a frame step S_SMUL,
// S_OFS and S_CLAMP; a tick adds S_TMUL unless ignored, S_TCMP if large enough, S_TMOD to wrap.
// Throughput: one item at a time; the next is taken the cycle after the result is loaded into
// the output register, which holds it until the sink takes it. Frame outputs use four multiplies.
// Reset (synchronous, active low): position 0, paused, next tick discarded, registers default.
module media_playback_position_timer_core
    import mpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: elapsed_time[31:0], seek_value[79:32], frame_count[95:80]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[3:0]
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: play_position[46:0], current_frame[78:47], total_frames[110:79],
    //        is_running[111], moved[112], wrapped[113], reached_end[114], zero[119:115]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CMD   = 4'd1;
    localparam logic [3:0] S_TMUL  = 4'd2;
    localparam logic [3:0] S_TCMP  = 4'd3;
    localparam logic [3:0] S_TMOD  = 4'd4;
    localparam logic [3:0] S_SMUL  = 4'd5;
    localparam logic [3:0] S_OFS   = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_FA    = 4'd8;
    localparam logic [3:0] S_FB    = 4'd9;
    localparam logic [3:0] S_FC    = 4'd10;
    localparam logic [3:0] S_FD    = 4'd11;
    localparam logic [3:0] S_FE    = 4'd12;
    localparam logic [3:0] S_FF    = 4'd13;

    // Control and configuration
    logic [3:0]           r_state;
    logic                 r_run;
    logic                 r_disc;
    logic [POS_WIDTH-1:0] r_pos;
    logic [DUR_W-1:0]     r_dur;
    logic                 r_loop;
    logic [SPEED_W-1:0]   r_speed;
    logic [RATE_W-1:0]    r_rate;
    logic [FPER_W-1:0]    r_fper;
    logic                 r_ovalid;

    // Latched item and working registers
    logic [KIND_W-1:0]    r_kind;
    logic [ELAP_W-1:0]    r_elap;
    logic [SV_W-1:0]      r_sv;
    logic [FCNT_W-1:0]    r_fcnt;
    logic [SV_W-1:0]      r_mag;
    logic                 r_neg;
    logic [TGT_W-1:0]     r_tgt;
    logic [SUM_W-1:0]     r_sum;
    logic [PLO_W-1:0]     r_plo;
    logic [PF_W-1:0]      r_full;
    logic [FRAME_W-1:0]   r_cur;
    logic                 r_moved;
    logic                 r_wrap;
    logic                 r_end;

    // Output register
    logic [POS_WIDTH-1:0] r_o_pos;
    logic [FRAME_W-1:0]   r_o_cur;
    logic [FRAME_W-1:0]   r_o_tot;
    logic                 r_o_run;
    logic                 r_o_moved;
    logic                 r_o_wrap;
    logic                 r_o_end;

    logic                 w_in_acc;
    logic [POS_WIDTH-1:0] w_deff;
    logic [POS_WIDTH-1:0] w_cfg_deff;
    logic [MUL_W-1:0]     w_mul_a;
    logic [MUL_W-1:0]     w_mul_b;
    logic [PROD_W-1:0]    w_prod;
    logic [MUL_W-1:0]     w_per;
    logic [DELTA_W-1:0]   w_delta;
    logic [SV_W-1:0]      w_sv_mag;
    logic [TGT_W-1:0]     w_fwd;
    logic [TGT_W:0]       w_back;
    logic [POS_WIDTH-1:0] w_sat;
    logic [POS_WIDTH-1:0] w_clp;
    logic                 w_ge_end;
    logic                 w_mod_start;
    logic                 w_mod_done;
    logic [POS_WIDTH-1:0] w_mod_rem;
    logic                 w_out_free;
    logic                 w_load;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_deff     = eff_dur(r_dur);
    assign w_cfg_deff = eff_dur(i_cfg_wdata[DUR_W-1:0]);
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_load     = (r_state == S_FF) && w_out_free;

    // Datapath terms
    always_comb begin
        w_per    = MUL_W'((34'(r_fper) << PER_SHL) >> PER_SHR);
        w_delta  = DELTA_W'(w_prod >> TICK_SHR);
        w_sv_mag = r_sv[SV_W-1] ? ((~r_sv) + SV_W'(1)) : r_sv;
        w_fwd    = TGT_W'(r_pos) + TGT_W'(r_mag);
        w_back   = (TGT_W + 1)'(r_pos) - (TGT_W + 1)'(r_mag);
        w_sat    = (|(r_tgt >> POS_WIDTH)) ? POS_MAX : POS_WIDTH'(r_tgt);
        w_clp    = ((w_deff != '0) && (w_sat > w_deff)) ? w_deff : w_sat;
        w_ge_end = r_sum >= SUM_W'(w_deff);
    end

    assign w_mod_start = (r_state == S_TCMP) && w_ge_end && r_loop;

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_CMD: begin
                if (r_kind inside {KIND_STEP_FWD, KIND_STEP_BACK}) begin
                    w_mul_a = MUL_W'(r_fcnt);
                    w_mul_b = w_per;
                end else begin
                    w_mul_a = r_elap;
                    w_mul_b = MUL_W'(r_speed);
                end
            end
            S_FA: begin
                w_mul_a = MUL_W'(r_pos);
                w_mul_b = MUL_W'(r_rate);
            end
            S_FB: begin
                w_mul_a = MUL_W'(r_pos >> MUL_W);
                w_mul_b = MUL_W'(r_rate);
            end
            S_FC: begin
                w_mul_a = MUL_W'(w_deff);
                w_mul_b = MUL_W'(r_rate);
            end
            S_FD: begin
                w_mul_a = MUL_W'(w_deff >> MUL_W);
                w_mul_b = MUL_W'(r_rate);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mpt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    mpt_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_sum),
        .i_divisor  (w_deff),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Sequencer, position state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_disc   <= 1'b1;
            r_pos    <= '0;
            r_dur    <= '0;
            r_loop   <= 1'b0;
            r_speed  <= SPEED_RST;
            r_rate   <= RATE_RST;
            r_fper   <= FPER_RST;
            r_ovalid <= 1'b0;
        end else begin
            // Output valid: set on load, cleared when the sink takes it
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind  <= i_s_axis_tuser;
                        r_elap  <= i_s_axis_tdata[31:0];
                        r_sv    <= i_s_axis_tdata[79:32];
                        r_fcnt  <= i_s_axis_tdata[95:80];
                        r_moved <= 1'b0;
                        r_wrap  <= 1'b0;
                        r_end   <= 1'b0;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    case (r_kind)
                        KIND_TICK: begin
                            if (r_run && (w_deff != '0) && !r_disc) begin
                                r_state <= S_TMUL;
                            end else begin
                                r_state <= S_FA;
                            end
                            if (r_run && (w_deff != '0) && r_disc) begin
                                r_disc <= 1'b0;
                            end
                        end
                        KIND_PLAY: begin
                            if (!r_run) begin
                                r_run  <= 1'b1;
                                r_disc <= 1'b1;
                            end
                            r_state <= S_FA;
                        end
                        KIND_PAUSE: begin
                            r_run   <= 1'b0;
                            r_state <= S_FA;
                        end
                        KIND_STOP: begin
                            r_run   <= 1'b0;
                            r_pos   <= '0;
                            r_moved <= 1'b1;
                            r_state <= S_FA;
                        end
                        KIND_TOGGLE: begin
                            r_run <= !r_run;
                            if (!r_run) begin
                                r_disc <= 1'b1;
                            end
                            r_state <= S_FA;
                        end
                        KIND_SEEK, KIND_SYNC: begin
                            r_tgt   <= r_sv[SV_W-1] ? '0 : TGT_W'(r_sv);
                            r_state <= S_CLAMP;
                        end
                        KIND_SEEK_REL: begin
                            r_mag   <= w_sv_mag;
                            r_neg   <= r_sv[SV_W-1];
                            r_state <= S_OFS;
                        end
                        KIND_STEP_FWD, KIND_STEP_BACK: begin
                            r_state <= S_SMUL;
                        end
                        KIND_SEEK_END: begin
                            r_tgt   <= TGT_W'(w_deff);
                            r_state <= S_CLAMP;
                        end
                        default: begin
                            r_state <= S_FA;
                        end
                    endcase
                end
                // Tick: scaled advance, skip tiny ones
                S_TMUL: begin
                    r_sum <= SUM_W'(r_pos) + SUM_W'(w_delta);
                    if (w_delta < DELTA_W'(SKIP_UNITS)) begin
                        r_state <= S_FA;
                    end else begin
                        r_state <= S_TCMP;
                    end
                end
                // Commit the advance, or at the end of the timeline wrap through the modulo unit or stop there
                S_TCMP: begin
                    if (w_ge_end) begin
                        if (r_loop) begin
                            r_state <= S_TMOD;
                        end else begin
                            r_pos   <= w_deff;
                            r_run   <= 1'b0;
                            r_end   <= 1'b1;
                            r_moved <= (w_deff != r_pos);
                            r_state <= S_FA;
                        end
                    end else begin
                        r_pos   <= POS_WIDTH'(r_sum);
                        r_moved <= 1'b1;
                        r_state <= S_FA;
                    end
                end
                S_TMOD: begin
                    if (w_mod_done) begin
                        r_pos   <= w_mod_rem;
                        r_wrap  <= 1'b1;
                        r_moved <= (w_mod_rem != r_pos);
                        r_state <= S_FA;
                    end
                end
                // Frame step length from the multiplier
                S_SMUL: begin
                    r_mag   <= SV_W'(w_prod);
                    r_neg   <= (r_kind == KIND_STEP_BACK);
                    r_state <= S_OFS;
                end
                // Relative target, floored at zero going back
                S_OFS: begin
                    if (r_neg) begin
                        r_tgt <= w_back[TGT_W] ? '0 : TGT_W'(w_back);
                    end else begin
                        r_tgt <= w_fwd;
                    end
                    r_state <= S_CLAMP;
                end
                // Clamp to the timeline and commit the seek
                S_CLAMP: begin
                    r_pos   <= w_clp;
                    r_disc  <= 1'b1;
                    r_moved <= (r_kind != KIND_SYNC) && (w_clp != r_pos);
                    r_state <= S_FA;
                end
                // Frame numbers from four partial products
                S_FA: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_plo   <= PLO_W'(w_prod);
                    r_state <= S_FC;
                end
                S_FC: begin
                    r_full  <= (PF_W'(w_prod) << MUL_W) + PF_W'(r_plo);
                    r_state <= S_FD;
                end
                S_FD: begin
                    r_cur   <= frames_of(r_full, 1'b0);
                    r_plo   <= PLO_W'(w_prod);
                    r_state <= S_FE;
                end
                S_FE: begin
                    r_full  <= (PF_W'(w_prod) << MUL_W) + PF_W'(r_plo);
                    r_state <= S_FF;
                end
                S_FF: begin
                    if (w_out_free) begin
                        r_o_pos   <= r_pos;
                        r_o_cur   <= r_cur;
                        r_o_tot   <= frames_of(r_full, 1'b1);
                        r_o_run   <= r_run;
                        r_o_moved <= r_moved;
                        r_o_wrap  <= r_wrap;
                        r_o_end   <= r_end;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes; the host must issue them only while no item is in flight, the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_DURATION: begin
                        r_dur <= i_cfg_wdata[DUR_W-1:0];
                        if ((w_cfg_deff != '0) && (r_pos > w_cfg_deff)) begin
                            r_pos <= w_cfg_deff;
                        end
                    end
                    REG_LOOP_ENABLE: begin
                        r_loop <= i_cfg_wdata[0];
                    end
                    REG_SPEED: begin
                        r_speed <= i_cfg_wdata[SPEED_W-1:0];
                    end
                    REG_FRAME_RATE: begin
                        r_rate <= i_cfg_wdata[RATE_W-1:0];
                    end
                    REG_FRAME_PERIOD: begin
                        r_fper <= i_cfg_wdata[FPER_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'b0, r_o_end, r_o_wrap, r_o_moved, r_o_run,
                              r_o_tot, r_o_cur, r_o_pos};

`ifndef SYNTHESIS
    // A result never appears in the cycle right after its transaction
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(o_m_axis_tvalid))
        else $error("result raised directly after input transaction");

    // Position stays within the timeline
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deff != '0) |-> (r_pos <= w_deff))
        else $error("position beyond duration");

    // Modulo unit only runs for a looping tick
    a_mod_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |-> (r_loop && (w_deff != '0)))
        else $error("modulo started without loop or duration");

    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_TMOD))
        else $error("modulo result outside wrap state");

    // End of playback excludes running and wrapping
    a_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_o_end && (r_o_run || r_o_wrap)))
        else $error("inconsistent end flags");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top
    import mpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Kind outside the command set, must leave the state alone
    localparam logic [KIND_W-1:0] KIND_SPARE = 4'd15;
    // Register indexes beyond the defined set
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_CAP    = 100;
    localparam logic [63:0] SKIP_FLOOR = ((64'd1 << POS_FRAC_BITS) + 64'd9999) / 64'd10000;
    localparam int FRAME_SHIFT = POS_FRAC_BITS + 16;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FCNT_W-1:0] fcount;
        logic [SV_W-1:0]   seek;
        logic [ELAP_W-1:0] elapsed;
    } cmd_t;

    // Same order as the result tdata, lowest field last
    typedef struct packed {
        logic               reached_end;
        logic               wrapped;
        logic               moved;
        logic               running;
        logic [FRAME_W-1:0] total;
        logic [FRAME_W-1:0] frame;
        logic [POS_WIDTH-1:0] pos;
    } status_t;

    localparam int STATUS_W = $bits(status_t);

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wval;
        cmd_t                  cmd;
        bit                    fixed;
        status_t               want;
    } plan_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire o_s_axis_tready;
    wire o_m_axis_tvalid;
    wire [OUT_DATA_W-1:0] o_m_axis_tdata;

    media_playback_position_timer_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Registers and timeline state as the block should hold them
    logic [DUR_W-1:0]     reg_dur   = '0;
    logic                 reg_loop  = 1'b0;
    logic [SPEED_W-1:0]   reg_speed = 16'd256;
    logic [RATE_W-1:0]    reg_rate  = 25'd1572864;
    logic [FPER_W-1:0]    reg_fper  = 26'd2731;
    logic [POS_WIDTH-1:0] pos_now   = '0;
    logic                 playing   = 1'b0;
    logic                 skip_tick = 1'b1;

    status_t   status_q[$];
    plan_row_t plan[$];
    int fault_count = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_max = 4;
    int sink_mode = 1;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] dur_span();
        return (64'(reg_dur) > POS_MAX64) ? POS_MAX64 : 64'(reg_dur);
    endfunction

    function automatic logic [63:0] clamp_span(input logic [63:0] p);
        logic [63:0] d;
        d = dur_span();
        if (p > POS_MAX64) p = POS_MAX64;
        if (d != 64'd0 && p > d) p = d;
        return p;
    endfunction

    // floor or ceiling of a * rate / 2^(F+16), saturated to 32 bits
    function automatic logic [FRAME_W-1:0] frames_at(input logic [63:0] a, input bit round_up);
        logic [95:0] prod;
        logic [95:0] q;
        prod = 96'(a) * 96'(reg_rate);
        q = prod >> FRAME_SHIFT;
        if (round_up && (prod & ((96'd1 << FRAME_SHIFT) - 96'd1)) != 96'd0) q = q + 96'd1;
        return (q > 96'hFFFF_FFFF) ? '1 : q[FRAME_W-1:0];
    endfunction

    function automatic bit jump_to(input logic [63:0] target);
        logic [POS_WIDTH-1:0] prior;
        prior = pos_now;
        pos_now = POS_WIDTH'(clamp_span(target));
        skip_tick = 1'b1;
        return pos_now != prior;
    endfunction

    function automatic logic [63:0] offset_from_pos(input bit back, input logic [63:0] mag);
        if (back) return (64'(pos_now) >= mag) ? 64'(pos_now) - mag : 64'd0;
        if (mag > POS_MAX64) return POS_MAX64;
        return 64'(pos_now) + mag;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DURATION: begin
                reg_dur = val[DUR_W-1:0];
                if (reg_dur != '0) pos_now = POS_WIDTH'(clamp_span(64'(pos_now)));
            end
            REG_LOOP_ENABLE:  reg_loop  = val[0];
            REG_SPEED:        reg_speed = val[SPEED_W-1:0];
            REG_FRAME_RATE:   reg_rate  = val[RATE_W-1:0];
            REG_FRAME_PERIOD: reg_fper  = val[FPER_W-1:0];
            default: ;
        endcase
    endfunction

    // Moves the timeline by one command and returns the status it reports
    function automatic status_t advance_timeline(input cmd_t c);
        status_t r;
        logic [63:0] d, delta, sum, mag, step;
        logic [SV_W-1:0] flipped;
        logic [POS_WIDTH-1:0] prior;
        bit neg;
        r = '0;
        d = dur_span();
        neg = c.seek[SV_W-1];
        flipped = -c.seek;
        mag = neg ? 64'(flipped) : 64'(c.seek);
        step = 64'(c.fcount) * ((64'(reg_fper) << PER_SHL) >> PER_SHR);
        case (c.kind)
            KIND_TICK: begin
                if (playing && d != 64'd0) begin
                    if (skip_tick) begin
                        skip_tick = 1'b0;
                    end else begin
                        delta = (64'(c.elapsed) * 64'(reg_speed)) >> TICK_SHR;
                        if (delta >= SKIP_FLOOR) begin
                            prior = pos_now;
                            sum = 64'(pos_now) + delta;
                            if (sum >= d) begin
                                if (reg_loop) begin
                                    sum = sum % d;
                                    r.wrapped = 1'b1;
                                end else begin
                                    sum = d;
                                    playing = 1'b0;
                                    r.reached_end = 1'b1;
                                end
                            end
                            pos_now = POS_WIDTH'(sum);
                            r.moved = pos_now != prior;
                        end
                    end
                end
            end
            KIND_PLAY: begin
                if (!playing) begin
                    playing = 1'b1;
                    skip_tick = 1'b1;
                end
            end
            KIND_PAUSE: playing = 1'b0;
            KIND_STOP: begin
                playing = 1'b0;
                pos_now = '0;
                r.moved = 1'b1;
            end
            KIND_TOGGLE: begin
                if (playing) begin
                    playing = 1'b0;
                end else begin
                    playing = 1'b1;
                    skip_tick = 1'b1;
                end
            end
            KIND_SEEK:      r.moved = jump_to(neg ? 64'd0 : mag);
            KIND_SEEK_REL:  r.moved = jump_to(offset_from_pos(neg, mag));
            KIND_STEP_FWD:  r.moved = jump_to(offset_from_pos(1'b0, step));
            KIND_STEP_BACK: r.moved = jump_to(offset_from_pos(1'b1, step));
            KIND_SYNC: begin
                pos_now = POS_WIDTH'(clamp_span(neg ? 64'd0 : mag));
                skip_tick = 1'b1;
            end
            KIND_SEEK_END:  r.moved = jump_to(d);
            default: ;
        endcase
        r.pos = pos_now;
        r.frame = frames_at(64'(pos_now), 1'b0);
        r.total = frames_at(d, 1'b1);
        r.running = playing;
        return r;
    endfunction

    // ---------------------------------------------------------------- directed table

    function automatic status_t outcome(input logic [POS_WIDTH-1:0] pos,
                                        input logic [FRAME_W-1:0] frame,
                                        input logic [FRAME_W-1:0] total,
                                        input logic running, input logic moved);
        status_t s;
        s = '0;
        s.pos = pos;
        s.frame = frame;
        s.total = total;
        s.running = running;
        s.moved = moved;
        return s;
    endfunction

    function automatic void add_cmd(input logic [KIND_W-1:0] kind,
                                    input logic [ELAP_W-1:0] elapsed,
                                    input logic [SV_W-1:0] seek,
                                    input logic [FCNT_W-1:0] fcount,
                                    input bit fixed = 1'b0, input status_t want = '0);
        plan_row_t row;
        row = '{default: '0};
        row.cmd = '{kind: kind, fcount: fcount, seek: seek, elapsed: elapsed};
        row.fixed = fixed;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx = idx;
        row.wval = val;
        plan.push_back(row);
    endfunction

    function automatic void build_plan();
        // reset registers: no duration, 24 fps
        add_cmd(KIND_SPARE, '1, '1, '1, 1'b1, outcome('0, '0, '0, 1'b0, 1'b0));
        add_cmd(KIND_TICK, '1, '0, '0, 1'b1, outcome('0, '0, '0, 1'b0, 1'b0));
        add_cmd(KIND_PLAY, '0, '0, '0, 1'b1, outcome('0, '0, '0, 1'b1, 1'b0));
        add_cmd(KIND_TICK, '1, '0, '0, 1'b1, outcome('0, '0, '0, 1'b1, 1'b0));
        add_cmd(KIND_PLAY, '0, '0, '0, 1'b1, outcome('0, '0, '0, 1'b1, 1'b0));
        add_cmd(KIND_SEEK, '0, 48'h7FFF_FFFF_FFFF, '0, 1'b1,
                outcome(POS_MAX, '1, '0, 1'b1, 1'b1));
        add_cmd(KIND_SEEK_REL, '0, 48'h7FFF_FFFF_FFFF, '0, 1'b1,
                outcome(POS_MAX, '1, '0, 1'b1, 1'b0));
        add_cmd(KIND_SEEK, '0, 48'h8000_0000_0000, '0, 1'b1,
                outcome('0, '0, '0, 1'b1, 1'b1));
        add_cmd(KIND_SEEK_REL, '0, 48'h8000_0000_0000, '0, 1'b1,
                outcome('0, '0, '0, 1'b1, 1'b0));
        add_cmd(KIND_STEP_FWD, '0, '0, 16'hFFFF);
        add_cmd(KIND_STEP_BACK, '0, '0, 16'd1);
        add_cmd(KIND_SYNC, '0, 48'h0003_0000_8000, '0);
        add_cmd(KIND_SEEK_END, '0, '0, '0);
        add_cmd(KIND_TOGGLE, '0, '0, '0);
        add_cmd(KIND_TOGGLE, '0, '0, '0);
        add_cmd(KIND_STOP, '0, '0, '0, 1'b1, outcome('0, '0, '0, 1'b0, 1'b1));
        // ten seconds, no frame rate, no frame period, writes to unused indexes
        add_write(REG_DURATION, 47'd10 << POS_FRAC_BITS);
        add_write(REG_FRAME_RATE, '0);
        add_write(REG_FRAME_PERIOD, '0);
        add_write(REG_UNUSED_HI, '1);
        add_write(REG_UNUSED_LO, 47'h1234);
        add_cmd(KIND_PLAY, '0, '0, '0);
        add_cmd(KIND_TICK, 32'h0001_0000, '0, '0);
        add_cmd(KIND_TICK, 32'd6, '0, '0);
        add_cmd(KIND_TICK, 32'd7, '0, '0);
        add_cmd(KIND_STEP_FWD, '0, '0, 16'd3);
        add_cmd(KIND_TICK, 32'h0000_1000, '0, '0);
        add_cmd(KIND_TICK, '1, '0, '0);
        // looping, top speed, large rate and period
        add_write(REG_LOOP_ENABLE, 47'd1);
        add_write(REG_SPEED, 47'hFFFF);
        add_write(REG_FRAME_RATE, 47'd16777216);
        add_write(REG_FRAME_PERIOD, 47'd65536000);
        add_cmd(KIND_PLAY, '0, '0, '0);
        add_cmd(KIND_TICK, 32'h0000_0400, '0, '0);
        add_cmd(KIND_TICK, 32'h0003_0000, '0, '0);
        add_cmd(KIND_STEP_BACK, '0, '0, 16'hFFFF);
        add_cmd(KIND_SEEK_END, '0, '0, '0);
        add_cmd(KIND_PAUSE, '0, '0, '0);
    endfunction

    // ---------------------------------------------------------------- random stimulus

    function automatic cmd_t random_cmd();
        cmd_t c;
        logic [63:0] d;
        int pick;
        d = dur_span();
        pick = $urandom_range(0, 99);
        if (!playing && $urandom_range(0, 2) == 0) pick = 50;
        if (pick < 48)      c.kind = KIND_TICK;
        else if (pick < 56) c.kind = KIND_PLAY;
        else if (pick < 60) c.kind = KIND_TOGGLE;
        else if (pick < 63) c.kind = KIND_PAUSE;
        else if (pick < 65) c.kind = KIND_STOP;
        else if (pick < 71) c.kind = KIND_SEEK;
        else if (pick < 77) c.kind = KIND_SEEK_REL;
        else if (pick < 82) c.kind = KIND_STEP_FWD;
        else if (pick < 87) c.kind = KIND_STEP_BACK;
        else if (pick < 92) c.kind = KIND_SYNC;
        else if (pick < 96) c.kind = KIND_SEEK_END;
        else                c.kind = KIND_W'($urandom_range(11, 15));
        case ($urandom_range(0, 9))
            0:       c.elapsed = $urandom_range(0, 15);
            1, 2:    c.elapsed = $urandom;
            3:       c.elapsed = $urandom_range(0, 32'h0001_0000);
            4, 5, 6: c.elapsed = $urandom_range(0, 32'h0004_0000);
            default: c.elapsed = $urandom_range(500, 3000);
        endcase
        case ($urandom_range(0, 7))
            0:       c.seek = SV_W'({$urandom, $urandom});
            1:       c.seek = -SV_W'($urandom_range(0, 32'h0010_0000));
            2:       c.seek = 48'h7FFF_FFFF_FFFF;
            3:       c.seek = 48'h8000_0000_0000;
            4:       c.seek = SV_W'($urandom_range(0, 32'h0010_0000));
            default: c.seek = (d == 64'd0) ? SV_W'({$urandom, $urandom})
                                            : SV_W'({$urandom, $urandom} % (d + 64'd1));
        endcase
        if (c.kind == KIND_SEEK_REL && $urandom_range(0, 1) == 1 && d != 64'd0)
            c.seek = SV_W'($urandom_range(0, 32'h0002_0000)) * (($urandom_range(0, 1)) ? 1 : -1);
        c.fcount = ($urandom_range(0, 4) == 0) ? FCNT_W'($urandom) : FCNT_W'($urandom_range(0, 10));
        return c;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender idles and waits until every result is back
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_cmd(input cmd_t c, input bit fixed, input status_t want);
        int gap;
        status_t r;
        @(negedge clk);
        // bursts of back-to-back items separated by random gaps
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {c.fcount, c.seek, c.elapsed};
        s_tuser <= c.kind;
        do @(posedge clk); while (!o_s_axis_tready);
        r = advance_timeline(c);
        status_q.push_back(fixed ? want : r);
    endtask

    task automatic pick_setup();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = CFG_DATA_W'({$urandom, $urandom});
            default: v = (47'($urandom_range(1, 8)) << POS_FRAC_BITS) + 47'($urandom_range(0, 65535));
        endcase
        write_reg(REG_DURATION, v);
        write_reg(REG_LOOP_ENABLE, 47'($urandom_range(0, 1)));
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 47'hFFFF;
            2:       v = 47'($urandom_range(0, 16'hFFFF));
            default: v = 47'($urandom_range(128, 2048));
        endcase
        write_reg(REG_SPEED, v);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 47'd66;
            2:       v = 47'd16777216;
            3:       v = 47'($urandom_range(0, 25'h1FF_FFFF));
            default: v = 47'($urandom_range(1, 120)) << 16;
        endcase
        write_reg(REG_FRAME_RATE, v);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 47'd1;
            2:       v = 47'd65536000;
            3:       v = 47'($urandom_range(0, 26'h3FF_FFFF));
            default: v = 47'($urandom_range(546, 65536));
        endcase
        write_reg(REG_FRAME_PERIOD, v);
    endtask

    // Sink holds tready in stretches whose shape depends on the mode
    initial begin
        int hold;
        logic nxt;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                case (sink_mode)
                    0: begin
                        nxt = 1'b1;
                        hold = 16;
                    end
                    1: begin
                        nxt = 1'($urandom_range(0, 1));
                        hold = $urandom_range(0, 3);
                    end
                    default: begin
                        nxt = !m_tready;
                        hold = nxt ? $urandom_range(0, 6) : $urandom_range(1, 20);
                    end
                endcase
                m_tready <= nxt;
            end else begin
                hold--;
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        // printing stops after a while, counting does not
        if (fault_count < REPORT_CAP)
            $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        fault_count++;
    endtask

    always @(posedge clk) begin : result_check
        status_t got;
        status_t want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got = status_t'(o_m_axis_tdata[STATUS_W-1:0]);
            if (status_q.size() == 0) begin
                note_mismatch("unexpected transaction", 64'(got.pos), 64'd0);
            end else begin
                want = status_q.pop_front();
                if (got.pos != want.pos)
                    note_mismatch("play_position", 64'(got.pos), 64'(want.pos));
                if (got.frame != want.frame)
                    note_mismatch("current_frame", 64'(got.frame), 64'(want.frame));
                if (got.total != want.total)
                    note_mismatch("total_frames", 64'(got.total), 64'(want.total));
                if (got.running != want.running)
                    note_mismatch("is_running", 64'(got.running), 64'(want.running));
                if (got.moved != want.moved)
                    note_mismatch("moved", 64'(got.moved), 64'(want.moved));
                if (got.wrapped != want.wrapped)
                    note_mismatch("wrapped", 64'(got.wrapped), 64'(want.wrapped));
                if (got.reached_end != want.reached_end)
                    note_mismatch("reached_end", 64'(got.reached_end), 64'(want.reached_end));
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any transaction or register write
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int sent;
        int n;
        build_plan();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].wval);
            end else begin
                send_cmd(plan[i].cmd, plan[i].fixed, plan[i].want);
            end
        end

        // random phases, each under its own register setting and idling pattern
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            pick_setup();
            sink_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            n = $urandom_range(60, 200);
            while (n > 0) begin
                cmd_t c;
                c = random_cmd();
                send_cmd(c, 1'b0, '0);
                if (c.kind <= KIND_SEEK_END) begin
                    n--;
                    sent++;
                end
                if ($urandom_range(0, 149) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && status_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
